[rtl/rne_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roman numeral encoder package
// Field widths, symbol codes and the per-digit symbol rules.
// ----------------------------------------------------------------------------
package rne_pkg;

   // field widths
   localparam int NUMBER_WIDTH = 14;
   localparam int SYMBOL_WIDTH = 3;
   localparam int DIGIT_WIDTH  = 4;
   localparam int BCD_DIGITS   = 4;
   localparam int BCD_WIDTH    = DIGIT_WIDTH * BCD_DIGITS;
   localparam int REQ_DATA_WIDTH = 16;
   localparam int RSP_DATA_WIDTH = 8;

   // largest number that has a roman form here
   localparam logic [NUMBER_WIDTH-1:0] MAX_NUMBER = 14'd9999;

   // symbol codes
   localparam logic [SYMBOL_WIDTH-1:0] SYM_I = 3'd0;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_V = 3'd1;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_X = 3'd2;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_L = 3'd3;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_C = 3'd4;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_D = 3'd5;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_M = 3'd6;

   // decimal digit values with a rule of their own
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_FOUR = 4'd4;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_FIVE = 4'd5;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_NINE = 4'd9;

   // number of symbols one digit needs; the thousands digit is a plain run of M
   function automatic logic [DIGIT_WIDTH-1:0] digit_length(
      input logic [DIGIT_WIDTH-1:0] d,
      input logic                   is_thousands
   );
      logic [DIGIT_WIDTH-1:0] len;
      if (is_thousands) begin
         len = d;
      end else if (d == DIGIT_NINE || d == DIGIT_FOUR) begin
         len = 4'd2;
      end else if (d >= DIGIT_FIVE) begin
         len = d - 4'd4;
      end else begin
         len = d;
      end
      return len;
   endfunction

   // symbol number k of a digit at decimal position pos (0 = ones, 3 = thousands)
   function automatic logic [SYMBOL_WIDTH-1:0] digit_symbol(
      input logic [DIGIT_WIDTH-1:0] d,
      input logic [DIGIT_WIDTH-1:0] k,
      input logic [1:0]             pos
   );
      logic [SYMBOL_WIDTH-1:0] one;
      logic [SYMBOL_WIDTH-1:0] five;
      logic [SYMBOL_WIDTH-1:0] ten;
      logic [SYMBOL_WIDTH-1:0] sym;
      one  = {pos, 1'b0};
      five = one + 3'd1;
      ten  = one + 3'd2;
      if (pos == 2'd3) begin
         sym = SYM_M;
      end else if (d == DIGIT_NINE) begin
         sym = (k == 4'd0) ? one : ten;
      end else if (d == DIGIT_FOUR) begin
         sym = (k == 4'd0) ? one : five;
      end else if (d >= DIGIT_FIVE) begin
         sym = (k == 4'd0) ? five : one;
      end else begin
         sym = one;
      end
      return sym;
   endfunction

endpackage

[rtl/roman_numeral_encoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roman numeral encoder
// Converts a binary number of 1 to 9999 into its roman numeral, one symbol
// per output item, with the last symbol marked.
// ----------------------------------------------------------------------------
//
//  channel  direction  tdata                        tuser         tlast
//  req_     in         [13:0] number_in             -             -
//  rsp_     out        [2:0] symbol                 range_error   last_symbol
//
//  an item is accepted, converted from binary to bcd bit-serially (one bit
//  per cycle), then written out one symbol at a time whenever the output
//  register is free; each leading or inner zero digit is passed over with
//  no item. an out-of-range number gives one error item after
//  the accept cycle. one item is worked on at a time; the output register
//  holds its item while rsp_tready is low and emission waits behind it.
//  reset is synchronous; there is no storage to clear.
//
module roman_numeral_encoder_unit (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rne_pkg::REQ_DATA_WIDTH-1:0] req_tdata,  // [13:0] number_in
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rne_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,  // [2:0] symbol
   output logic                              rsp_tuser,   // [0] range_error
   output logic                              rsp_tlast    // last_symbol
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT,
      ST_FAULT
   } state_type;

   state_type                                state_ff, state_in;
   logic [rne_pkg::NUMBER_WIDTH-1:0]         bin_ff, bin_in;
   logic [rne_pkg::BCD_WIDTH-1:0]            bcd_ff, bcd_in;
   logic [3:0]                               cnt_ff, cnt_in;
   logic [1:0]                               idx_ff, idx_in;
   logic [rne_pkg::DIGIT_WIDTH-1:0]          k_ff, k_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic [rne_pkg::SYMBOL_WIDTH-1:0]         rsp_symbol_ff, rsp_symbol_in;
   logic                                     rsp_last_ff, rsp_last_in;
   logic                                     rsp_error_ff, rsp_error_in;

   logic                                     req_accept;
   logic                                     out_free;
   logic [rne_pkg::NUMBER_WIDTH-1:0]         number_in;
   logic                                     number_bad;
   logic [rne_pkg::BCD_WIDTH-1:0]            bcd_adj;
   logic [rne_pkg::DIGIT_WIDTH-1:0]          cur_digit;
   logic [rne_pkg::DIGIT_WIDTH-1:0]          cur_len;
   logic [rne_pkg::SYMBOL_WIDTH-1:0]         cur_sym;
   logic [1:0]                               cur_pos;
   logic                                     lower_zero;
   logic                                     digit_done;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign number_in  = req_tdata[rne_pkg::NUMBER_WIDTH-1:0];
   assign number_bad = (number_in == '0) || (number_in > rne_pkg::MAX_NUMBER);

   // add-3 correction on each bcd digit ahead of the shift
   always_comb begin
      for (int i = 0; i < rne_pkg::BCD_DIGITS; i++) begin
         if (bcd_ff[i*rne_pkg::DIGIT_WIDTH +: rne_pkg::DIGIT_WIDTH] >= rne_pkg::DIGIT_FIVE) begin
            bcd_adj[i*rne_pkg::DIGIT_WIDTH +: rne_pkg::DIGIT_WIDTH] =
               bcd_ff[i*rne_pkg::DIGIT_WIDTH +: rne_pkg::DIGIT_WIDTH] + 4'd3;
         end else begin
            bcd_adj[i*rne_pkg::DIGIT_WIDTH +: rne_pkg::DIGIT_WIDTH] =
               bcd_ff[i*rne_pkg::DIGIT_WIDTH +: rne_pkg::DIGIT_WIDTH];
         end
      end
   end

   // current digit, thousands first, and whether all digits after it are zero
   always_comb begin
      case (idx_ff)
         2'd0: begin
            cur_digit  = bcd_ff[15:12];
            lower_zero = (bcd_ff[11:0] == '0);
         end
         2'd1: begin
            cur_digit  = bcd_ff[11:8];
            lower_zero = (bcd_ff[7:0] == '0);
         end
         2'd2: begin
            cur_digit  = bcd_ff[7:4];
            lower_zero = (bcd_ff[3:0] == '0);
         end
         default: begin
            cur_digit  = bcd_ff[3:0];
            lower_zero = 1'b1;
         end
      endcase
   end

   // decimal position counts up from the ones: 3 - idx
   assign cur_pos    = ~idx_ff;
   assign cur_len    = rne_pkg::digit_length(cur_digit, idx_ff == 2'd0);
   assign cur_sym    = rne_pkg::digit_symbol(cur_digit, k_ff, cur_pos);
   assign digit_done = (k_ff == cur_len - 4'd1);

   // sequencer next-state logic
   always_comb begin
      state_in      = state_ff;
      bin_in        = bin_ff;
      bcd_in        = bcd_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      k_in          = k_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_error_in  = rsp_error_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               bin_in   = number_in;
               bcd_in   = '0;
               cnt_in   = 4'd0;
               idx_in   = 2'd0;
               k_in     = '0;
               state_in = number_bad ? ST_FAULT : ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            bcd_in = {bcd_adj[rne_pkg::BCD_WIDTH-2:0], bin_ff[rne_pkg::NUMBER_WIDTH-1]};
            bin_in = {bin_ff[rne_pkg::NUMBER_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(rne_pkg::NUMBER_WIDTH - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cur_len == '0) begin
               // nothing to write for this digit, move on
               idx_in = idx_ff + 2'd1;
               k_in   = '0;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = cur_sym;
               rsp_last_in   = digit_done && lower_zero;
               rsp_error_in  = 1'b0;
               if (digit_done) begin
                  idx_in = idx_ff + 2'd1;
                  k_in   = '0;
                  if (lower_zero) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  k_in = k_ff + 4'd1;
               end
            end
         end
         ST_FAULT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = rne_pkg::SYM_I;
               rsp_last_in   = 1'b1;
               rsp_error_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= 4'd0;
         idx_ff       <= 2'd0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         k_ff         <= k_in;
      end
      bin_ff        <= bin_in;
      bcd_ff        <= bcd_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_error_ff  <= rsp_error_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(rne_pkg::RSP_DATA_WIDTH - rne_pkg::SYMBOL_WIDTH){1'b0}}, rsp_symbol_ff};
   assign rsp_tuser  = rsp_error_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   a_error_item_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata == '0)
      else $error("error item must be a lone last item with symbol zero");

   a_symbol_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[rne_pkg::SYMBOL_WIDTH-1:0] <= rne_pkg::SYM_M)
      else $error("symbol code out of range");

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("new item taken while one is in progress");

   a_convert_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CONVERT |-> cnt_ff < 4'(rne_pkg::NUMBER_WIDTH))
      else $error("conversion ran past the input width");

   a_symbol_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> (k_ff < cur_len) || (k_ff == '0 && cur_len == '0))
      else $error("symbol index beyond digit length");

endmodule
